// ===== sv/patt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Page allocation tracking table: shared definitions
// Field widths, request and status codes, and configuration defaults used by
// the tracking table and its page rounding divider.
// ============================================================================
package patt_pkg;

    // Field widths of the request and result items.
    localparam int OP_W        = 2;
    localparam int ADDR_W      = 48;
    localparam int SIZE_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int BYTES_W     = 32;
    localparam int TOTAL_W     = 41;
    localparam int SLOT_W      = 8;
    localparam int PAGES_W     = 16;
    localparam int PAGE_SIZE_W = 17;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_W      = ADDR_W + SIZE_W;
    localparam int OUT_USED  = STATUS_W + BYTES_W + TOTAL_W + SLOT_W;
    localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Defaults for the top level parameters and registers.
    localparam int TABLE_DEPTH_DEFAULT  = 256;
    localparam int ADDRESS_BITS_DEFAULT = 48;
    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RESET = 17'd4096;
    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_MAX   = 17'd65536;

    // Register indexes, decoded from the word address.
    typedef enum logic
    {
        REG_PAGE_SIZE = 1'b0,
        REG_UNUSED    = 1'b1
    } reg_index_t;

    // Request kinds.
    typedef enum logic [OP_W-1:0]
    {
        OP_RECORD  = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_TOO_MANY  = 2'd3
    } status_t;

endpackage

// ===== sv/patt_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Page rounding divider
// Restoring radix-2 divider: divides a byte size by the page size, producing
// one quotient bit per cycle. Quotient and remainder hold after done.
// ============================================================================
module patt_div
    import patt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SIZE_W-1:0]      dividend,
    input  logic [PAGE_SIZE_W-1:0] divisor,
    output logic                   done,
    output logic [SIZE_W-1:0]      quotient,
    output logic [PAGE_SIZE_W-1:0] remainder
);

    localparam int CNT_W = $clog2(SIZE_W + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SIZE_W-1:0]      quo_reg;
    logic [PAGE_SIZE_W-1:0] rem_reg;
    logic [PAGE_SIZE_W-1:0] div_reg;

    logic [PAGE_SIZE_W:0]   trial;
    logic [PAGE_SIZE_W:0]   diff;
    logic                   fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        trial = {rem_reg, quo_reg[SIZE_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SIZE_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SIZE_W-2:0], fits};
            rem_reg <= fits ? diff[PAGE_SIZE_W-1:0] : trial[PAGE_SIZE_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // The final remainder is always below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    // A new division never starts on top of one in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("divider started while busy");

    // Done follows only the last step of a division.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a finished division");

endmodule

// ===== sv/page_allocation_tracking_table.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Page allocation tracking table
// Keeps allocation records (address, page count) in an in-use chain and
// unused slots in a free chain, both linked through a link memory. Records
// allocations, releases and queries, and tracks the total bytes held.
// ============================================================================
//
//  Channel  Direction  Signals                         Carries
//  -------  ---------  ------------------------------  --------------------------
//  s_*      in         s_tvalid s_tready s_tdata s_tuser  one request per transfer
//  m_*      out        m_tvalid m_tready m_tdata        one result per request
//  APB      in/out     psel penable pwrite paddr ...    page_size register
//
//  A record request runs the bit-serial page rounding divider, then the
//  free-slot link read and the record/link writes. A query or a release
//  walks the in-use chain slot by slot; the single read port of the record
//  and link memories sets that walk rate.
//  After reset the table is ready at once: slots never used are tracked by a
//  fill counter, so there is no clearing pass.
//  A new request is accepted while a finished result waits in the output
//  register; a stalled output holds the next result until it is taken.
//
module page_allocation_tracking_table
    import patt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEFAULT,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // address[47:0], size_bytes[79:48]
    input  logic [OP_W-1:0]       s_tuser,   // operation[1:0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // status[1:0], block_bytes[33:2],
                                             // total_bytes[74:34], slot[82:75]

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SW       = $clog2(TABLE_DEPTH);
    localparam int LW       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam int REC_W    = KEY_BITS + PAGES_W;
    localparam int CALC_W   = SIZE_W + 1;
    localparam int PROD_W   = PAGES_W + PAGE_SIZE_W;
    localparam logic [LW-1:0] INVALID_SLOT = LW'(TABLE_DEPTH);

    typedef enum logic [10:0]
    {
        ST_IDLE       = 11'b00000000001,
        ST_DIV        = 11'b00000000010,
        ST_REC_CHK    = 11'b00000000100,
        ST_REC_UPD    = 11'b00000001000,
        ST_REC_TAIL   = 11'b00000010000,
        ST_WALK_START = 11'b00000100000,
        ST_WALK       = 11'b00001000000,
        ST_MUL        = 11'b00010000000,
        ST_REL_A      = 11'b00100000000,
        ST_REL_B      = 11'b01000000000,
        ST_DONE       = 11'b10000000000
    } state_t;

    // Control state.
    state_t                 state_reg, state_next;
    logic [LW-1:0]          head_reg, head_next;
    logic [LW-1:0]          tail_reg, tail_next;
    logic [LW-1:0]          free_reg, free_next;
    logic [LW-1:0]          fill_reg, fill_next;
    logic [LW-1:0]          used_reg, used_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [PAGE_SIZE_W-1:0] page_size_reg;
    logic                   m_tvalid_reg, m_tvalid_next;

    // Per-request working registers.
    op_t                    op_reg, op_next;
    logic [KEY_BITS-1:0]    addr_reg, addr_next;
    logic [CALC_W-1:0]      pages_reg, pages_next;
    logic [BYTES_W-1:0]     bytes_reg, bytes_next;
    status_t                status_reg, status_next;
    logic [LW-1:0]          slot_reg, slot_next;
    logic [LW-1:0]          cur_reg, cur_next;
    logic [LW-1:0]          prev_reg, prev_next;
    logic [LW-1:0]          nxt_reg, nxt_next;
    logic [LW-1:0]          pend_reg, pend_next;
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;

    // Memories and their ports.
    logic [REC_W-1:0]       rec_mem [TABLE_DEPTH];
    logic [LW-1:0]          link_mem [TABLE_DEPTH];
    logic [REC_W-1:0]       rec_rdata;
    logic [LW-1:0]          link_rdata;
    logic                   rd_en;
    logic [SW-1:0]          rd_idx;
    logic                   rec_we;
    logic [SW-1:0]          rec_widx;
    logic                   link_we;
    logic [SW-1:0]          link_widx;
    logic [LW-1:0]          link_wd;

    // Datapath helpers.
    logic [PAGE_SIZE_W-1:0] eff_ps;
    logic [PROD_W-1:0]      prod;
    logic                   div_start;
    logic                   div_done;
    logic [SIZE_W-1:0]      div_quo;
    logic [PAGE_SIZE_W-1:0] div_rem;
    logic                   out_free;
    logic                   cfg_write;
    reg_index_t             cfg_idx;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_idx   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            REG_PAGE_SIZE: prdata = APB_DATA_W'(page_size_reg);
            default:       prdata = '0;
        endcase
    end

    // Page size as used: zero acts as one, large values clamp to 64 KiB.
    always_comb
    begin
        if (page_size_reg == '0)
        begin
            eff_ps = PAGE_SIZE_W'(1);
        end
        else if (page_size_reg > PAGE_SIZE_MAX)
        begin
            eff_ps = PAGE_SIZE_MAX;
        end
        else
        begin
            eff_ps = page_size_reg;
        end
    end

    // Shared multiplier for block bytes, registered into bytes_reg.
    assign prod = pages_reg[PAGES_W-1:0] * eff_ps;

    patt_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (s_tdata[IN_W-1:ADDR_W]),
        .divisor   (eff_ps),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign div_start = s_tvalid && s_tready && (op_t'(s_tuser) == OP_RECORD);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Request sequencer.
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_next     = free_reg;
        fill_next     = fill_reg;
        used_next     = used_reg;
        total_next    = total_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        pages_next    = pages_reg;
        bytes_next    = bytes_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        pend_next     = pend_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        rd_en         = 1'b0;
        rd_idx        = '0;
        rec_we        = 1'b0;
        rec_widx      = '0;
        link_we       = 1'b0;
        link_widx     = '0;
        link_wd       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = op_t'(s_tuser);
                    addr_next   = s_tdata[KEY_BITS-1:0];
                    status_next = ST_OK;
                    bytes_next  = '0;
                    slot_next   = '0;
                    case (op_t'(s_tuser))
                        OP_RECORD:  state_next = ST_DIV;
                        OP_RELEASE: state_next = ST_WALK_START;
                        OP_QUERY:   state_next = ST_WALK_START;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end

            // Wait for the rounded page count.
            ST_DIV:
            begin
                if (div_done)
                begin
                    pages_next = CALC_W'(div_quo) + CALC_W'(div_rem != '0);
                    state_next = ST_REC_CHK;
                end
            end

            // A full table is checked before the page count limit.
            ST_REC_CHK:
            begin
                if (free_reg == INVALID_SLOT)
                begin
                    status_next = ST_FULL;
                    state_next  = ST_DONE;
                end
                else if (pages_reg[CALC_W-1:PAGES_W] != '0)
                begin
                    status_next = ST_TOO_MANY;
                    state_next  = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = free_reg[SW-1:0];
                    state_next = ST_REC_UPD;
                end
            end

            // Write the record; after a never-used slot the free chain goes on at the next slot.
            ST_REC_UPD:
            begin
                rec_we    = 1'b1;
                rec_widx  = free_reg[SW-1:0];
                link_we   = 1'b1;
                link_widx = free_reg[SW-1:0];
                link_wd   = INVALID_SLOT;
                if (free_reg == fill_reg)
                begin
                    pend_next = LW'(free_reg + 1'b1);
                    fill_next = LW'(fill_reg + 1'b1);
                end
                else
                begin
                    pend_next = link_rdata;
                end
                slot_next  = free_reg;
                bytes_next = prod[BYTES_W-1:0];
                state_next = ST_REC_TAIL;
            end

            // Append to the in-use chain and pop the free chain.
            ST_REC_TAIL:
            begin
                free_next = pend_reg;
                used_next = LW'(used_reg + 1'b1);
                if ((head_reg != INVALID_SLOT) && (tail_reg != INVALID_SLOT))
                begin
                    link_we   = 1'b1;
                    link_widx = tail_reg[SW-1:0];
                    link_wd   = slot_reg;
                end
                else
                begin
                    head_next = slot_reg;
                end
                tail_next  = slot_reg;
                total_next = total_reg + TOTAL_W'(bytes_reg);
                state_next = ST_DONE;
            end

            ST_WALK_START:
            begin
                if (head_reg == INVALID_SLOT)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = head_reg[SW-1:0];
                    cur_next   = head_reg;
                    prev_next  = INVALID_SLOT;
                    state_next = ST_WALK;
                end
            end

            // One chain entry per cycle: compare, else read the next entry.
            ST_WALK:
            begin
                if (rec_rdata[REC_W-1:PAGES_W] == addr_reg)
                begin
                    slot_next  = cur_reg;
                    pages_next = CALC_W'(rec_rdata[PAGES_W-1:0]);
                    nxt_next   = link_rdata;
                    state_next = ST_MUL;
                end
                else if (link_rdata == INVALID_SLOT)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = ST_DONE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_idx    = link_rdata[SW-1:0];
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                end
            end

            ST_MUL:
            begin
                bytes_next = prod[BYTES_W-1:0];
                state_next = (op_reg == OP_RELEASE) ? ST_REL_A : ST_DONE;
            end

            // Bypass the released entry from its predecessor.
            ST_REL_A:
            begin
                if (prev_reg != INVALID_SLOT)
                begin
                    link_we   = 1'b1;
                    link_widx = prev_reg[SW-1:0];
                    link_wd   = nxt_reg;
                end
                state_next = ST_REL_B;
            end

            // Push the slot onto the free chain and fix head and tail.
            ST_REL_B:
            begin
                link_we   = 1'b1;
                link_widx = slot_reg[SW-1:0];
                link_wd   = free_reg;
                free_next = slot_reg;
                if (used_reg != '0)
                begin
                    used_next = LW'(used_reg - 1'b1);
                end
                if (prev_reg == INVALID_SLOT)
                begin
                    head_next = nxt_reg;
                end
                if (tail_reg == slot_reg)
                begin
                    tail_next = prev_reg;
                end
                total_next = total_reg - TOTAL_W'(bytes_reg);
                state_next = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_next  = {
                        {(OUT_W - OUT_USED){1'b0}},
                        SLOT_W'(slot_reg),
                        total_reg,
                        (status_reg == ST_OK) ? bytes_reg : {BYTES_W{1'b0}},
                        status_reg
                    };
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= INVALID_SLOT;
            tail_reg      <= INVALID_SLOT;
            free_reg      <= '0;
            fill_reg      <= '0;
            used_reg      <= '0;
            total_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            page_size_reg <= PAGE_SIZE_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            free_reg     <= free_next;
            fill_reg     <= fill_next;
            used_reg     <= used_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_write && pready && (cfg_idx == REG_PAGE_SIZE))
            begin
                page_size_reg <= pwdata[PAGE_SIZE_W-1:0];
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        pages_reg   <= pages_next;
        bytes_reg   <= bytes_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        nxt_reg     <= nxt_next;
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Record memory: address key and page count.
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_widx] <= {addr_reg, pages_reg[PAGES_W-1:0]};
        end
        if (rd_en)
        begin
            rec_rdata <= rec_mem[rd_idx];
        end
    end

    // Link memory: next slot in whichever chain the slot belongs to.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_widx] <= link_wd;
        end
        if (rd_en)
        begin
            link_rdata <= link_mem[rd_idx];
        end
    end

    // The in-use count never exceeds the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= LW'(TABLE_DEPTH))
        else $error("in-use count above table depth");

    // The free chain is empty exactly when every slot is in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg == INVALID_SLOT) == (used_reg == LW'(TABLE_DEPTH)))
        else $error("free chain out of step with in-use count");

    // The in-use chain is empty exactly when nothing is recorded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == INVALID_SLOT) == (used_reg == '0))
        else $error("chain head out of step with in-use count");

    // Head and tail are empty together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == INVALID_SLOT) == (tail_reg == INVALID_SLOT))
        else $error("chain head and tail disagree");

endmodule
